### sv/gwm_pkg.sv
// Package for the glob wildcard matcher: pattern byte codes, register indexes
// and sizing constants shared by every module of the block. No dependencies.
package gwm_pkg;

	localparam int PATTERN_BYTES_DEF = 32;   // default pattern capacity
	localparam int PATTERN_WORDS     = 4;    // 64-bit pattern registers
	localparam int WORD_W            = 64;
	localparam int STORED_BYTES      = PATTERN_WORDS * 8;
	localparam int LEN_W             = 6;    // pattern_length register width
	localparam int CFG_IDX_W         = 3;
	localparam int BYTE_W            = 8;

	localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
	localparam logic [BYTE_W-1:0] QUERY_BYTE = 8'h3F;
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_VAL   = 8'h80;
	localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_WORD_0 = 3'd0,
		REG_PATTERN_WORD_1 = 3'd1,
		REG_PATTERN_WORD_2 = 3'd2,
		REG_PATTERN_WORD_3 = 3'd3,
		REG_PATTERN_LENGTH = 3'd4
	} reg_idx_t;

endpackage

### sv/glob_wildcard_matcher.sv
// Top level of the glob wildcard matcher: stream ports, configuration port.
// Depends on gwm_pkg, gwm_cfg, gwm_close and gwm_step.
//
// Matches a streamed text, one byte per transaction, against a shell-style
// pattern of up to PATTERN_BYTES bytes held in four 64-bit pattern words and
// a length register. The whole text must match the whole pattern: '*' takes
// zero or more bytes, '?' takes one byte and, when that byte has its top bit
// set, every continuation byte (10xxxxxx) after it, and any other byte takes
// only itself. A NUL byte in the pattern ends it early. One result transaction
// comes out per text, after the byte flagged tlast or after a single
// transaction flagged as an empty text in tuser. The block takes one byte per
// clock except while stalled as described below: a byte is registered on
// entry, the whole set of live pattern positions is updated from the
// registered byte, and a result lands in an output register. A waiting result
// stalls input only when a second text ends before the first result has been
// taken. Write the pattern only while no text is in flight; the configuration
// port never stalls.
module glob_wildcard_matcher #(
	parameter int PATTERN_BYTES = gwm_pkg::PATTERN_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// text in
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,   // [7:0] text_byte
	input  logic                            s_axis_tlast,   // last_of_text
	input  logic                            s_axis_tuser,   // [0] empty_text
	// match result out
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,   // [0] matched, [7:1] zero
	// pattern configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gwm_pkg::WORD_W-1:0]      cfg_data
);

	logic [PATTERN_BYTES-1:0]                 inuse, star_mask, query_mask;
	logic [PATTERN_BYTES*gwm_pkg::BYTE_W-1:0] lit_bytes;
	logic                                     matched;

	// pattern registers and their per-position masks
	gwm_cfg #(.PATTERN_BYTES(PATTERN_BYTES)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.inuse      (inuse),
		.star_mask  (star_mask),
		.query_mask (query_mask),
		.lit_bytes  (lit_bytes)
	);

	// advance the live-position set by one byte per transaction
	gwm_step #(.PATTERN_BYTES(PATTERN_BYTES)) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.in_empty    (s_axis_tuser),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_matched (matched),
		.inuse       (inuse),
		.star_mask   (star_mask),
		.query_mask  (query_mask),
		.lit_bytes   (lit_bytes)
	);

	// pad the result up to a whole byte
	assign m_axis_tdata = {7'b0, matched};

endmodule

### sv/gwm_cfg.sv
// Pattern configuration registers of the glob wildcard matcher, plus the
// per-position masks (in use, star, question) derived on each write.
// Depends on gwm_pkg.
module gwm_cfg #(
	parameter int PATTERN_BYTES = gwm_pkg::PATTERN_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gwm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gwm_pkg::WORD_W-1:0]          cfg_data,
	output logic [PATTERN_BYTES-1:0]            inuse,
	output logic [PATTERN_BYTES-1:0]            star_mask,
	output logic [PATTERN_BYTES-1:0]            query_mask,
	output logic [PATTERN_BYTES*gwm_pkg::BYTE_W-1:0] lit_bytes
);

	localparam int PB = PATTERN_BYTES;
	localparam int BW = gwm_pkg::BYTE_W;

	logic [gwm_pkg::WORD_W-1:0] word_q [gwm_pkg::PATTERN_WORDS];
	logic [gwm_pkg::LEN_W-1:0]  len_q;
	logic [gwm_pkg::WORD_W-1:0] word_n [gwm_pkg::PATTERN_WORDS];
	logic [gwm_pkg::LEN_W-1:0]  len_n;
	logic [PB-1:0]              nz_n, inuse_n, star_n, query_n;
	logic [PB-1:0]              inuse_q, star_q, query_q;
	logic                       wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;

	// merge the write into the register image so the masks follow it at once
	always_comb begin
		for (int w = 0; w < gwm_pkg::PATTERN_WORDS; w++) begin
			word_n[w] = word_q[w];
		end
		len_n = len_q;
		unique case (cfg_index)
			gwm_pkg::REG_PATTERN_WORD_0: word_n[0] = cfg_data;
			gwm_pkg::REG_PATTERN_WORD_1: word_n[1] = cfg_data;
			gwm_pkg::REG_PATTERN_WORD_2: word_n[2] = cfg_data;
			gwm_pkg::REG_PATTERN_WORD_3: word_n[3] = cfg_data;
			gwm_pkg::REG_PATTERN_LENGTH: len_n = cfg_data[gwm_pkg::LEN_W-1:0];
			default: ;
		endcase
	end

	always_comb begin
		logic [BW-1:0] b;
		for (int p = 0; p < PB; p++) begin
			if (p < gwm_pkg::STORED_BYTES) begin
				b = word_n[p / 8][(p % 8) * BW +: BW];
			end else begin
				b = gwm_pkg::NUL_BYTE;
			end
			nz_n[p]    = (b != gwm_pkg::NUL_BYTE);
			star_n[p]  = (b == gwm_pkg::STAR_BYTE);
			query_n[p] = (b == gwm_pkg::QUERY_BYTE);
		end
		// a position is in use below the length and before the first NUL
		for (int p = 0; p < PB; p++) begin
			inuse_n[p] = ({1'b0, len_n} > (gwm_pkg::LEN_W + 1)'(p))
				& (&(nz_n | ({PB{1'b1}} << (p + 1))));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < gwm_pkg::PATTERN_WORDS; w++) begin
				word_q[w] <= '0;
			end
			len_q   <= '0;
			inuse_q <= '0;
			star_q  <= '0;
			query_q <= '0;
		end else if (wr) begin
			word_q  <= word_n;
			len_q   <= len_n;
			inuse_q <= inuse_n;
			star_q  <= star_n & inuse_n;
			query_q <= query_n & inuse_n;
		end
	end

	always_comb begin
		for (int p = 0; p < PB; p++) begin
			if (p < gwm_pkg::STORED_BYTES) begin
				lit_bytes[p*BW +: BW] = word_q[p / 8][(p % 8) * BW +: BW];
			end else begin
				lit_bytes[p*BW +: BW] = gwm_pkg::NUL_BYTE;
			end
		end
	end

	assign inuse      = inuse_q;
	assign star_mask  = star_q;
	assign query_mask = query_q;

endmodule

### sv/gwm_close.sv
// Star closure of a live-position vector: a position holding '*' also makes
// the next one live, carried along runs of stars by a log-depth prefix network.
// Depends on gwm_pkg for its default size.
module gwm_close #(
	parameter int PATTERN_BYTES = gwm_pkg::PATTERN_BYTES_DEF
) (
	input  logic [PATTERN_BYTES:0]   live,
	input  logic [PATTERN_BYTES-1:0] star_mask,
	output logic [PATTERN_BYTES:0]   closed
);

	localparam int NPOS = PATTERN_BYTES + 1;

	always_comb begin
		logic [NPOS-1:0] g, pr, low;
		g  = live;
		pr = {star_mask, 1'b0};
		for (int d = 1; d < NPOS; d = d * 2) begin
			low = ~({NPOS{1'b1}} << d);
			g   = g | (pr & (g << d));
			pr  = pr & ((pr << d) | low);
		end
		closed = g;
	end

endmodule

### sv/gwm_step.sv
// Per-byte update of the glob wildcard matcher: input stage register, live and
// pending position state, and the result register. Depends on gwm_pkg and
// gwm_close.
module gwm_step #(
	parameter int PATTERN_BYTES = gwm_pkg::PATTERN_BYTES_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [gwm_pkg::BYTE_W-1:0]               in_byte,
	input  logic                                     in_last,
	input  logic                                     in_empty,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output logic                                     res_matched,
	input  logic [PATTERN_BYTES-1:0]                 inuse,
	input  logic [PATTERN_BYTES-1:0]                 star_mask,
	input  logic [PATTERN_BYTES-1:0]                 query_mask,
	input  logic [PATTERN_BYTES*gwm_pkg::BYTE_W-1:0] lit_bytes
);

	localparam int PB   = PATTERN_BYTES;
	localparam int NPOS = PB + 1;
	localparam int BW   = gwm_pkg::BYTE_W;
	localparam logic [NPOS-1:0] START = NPOS'(1);

	logic            valid_s1, last_s1, empty_s1;
	logic [BW-1:0]   byte_s1;
	logic [NPOS-1:0] act_q, pend_q;
	logic            out_valid_q, matched_q;

	logic [NPOS-1:0] upto, fin, cur0, curc, np0, na, np, endv;
	logic [PB-1:0]   lit_hit, cp;
	logic            cont, hi, produces, advance, res;

	assign upto = {inuse, 1'b1};
	assign fin  = {inuse, 1'b1} & ~{1'b0, inuse};
	assign cont = (byte_s1 & gwm_pkg::CONT_MASK) == gwm_pkg::CONT_VAL;
	assign hi   = byte_s1[BW-1];

	always_comb begin
		for (int p = 0; p < PB; p++) begin
			lit_hit[p] = inuse[p] & ~star_mask[p] & ~query_mask[p]
				& (lit_bytes[p*BW +: BW] == byte_s1);
		end
	end

	// an empty text starts from position zero alone; otherwise resume pending
	// '?' threads unless this byte is a continuation byte
	always_comb begin
		if (empty_s1) begin
			cur0 = START;
			np0  = '0;
		end else begin
			cur0 = (act_q | (cont ? '0 : pend_q)) & upto;
			np0  = (cont ? pend_q : '0) & upto;
		end
	end

	gwm_close #(.PATTERN_BYTES(PB)) u_close_cur (
		.live      (cur0),
		.star_mask (star_mask),
		.closed    (curc)
	);

	assign cp = curc[PB-1:0];
	assign na = {1'b0, cp & star_mask}
		| {cp & ((query_mask & {PB{~hi}}) | lit_hit), 1'b0};
	assign np = np0 | {cp & query_mask & {PB{hi}}, 1'b0};

	gwm_close #(.PATTERN_BYTES(PB)) u_close_end (
		.live      (na | np),
		.star_mask (star_mask),
		.closed    (endv)
	);

	assign res      = empty_s1 ? |(curc & fin) : |(endv & fin);
	assign produces = empty_s1 | last_s1;
	assign advance  = valid_s1 & (~produces | ~out_valid_q | res_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			act_q       <= START;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance && produces) begin
				act_q       <= START;
				pend_q      <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (advance) begin
					act_q  <= na;
					pend_q <= np;
				end
				if (res_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			last_s1  <= in_last;
			empty_s1 <= in_empty;
		end
		if (advance && produces) begin
			matched_q <= res;
		end
	end

	assign res_valid   = out_valid_q;
	assign res_matched = matched_q;

endmodule

### tb/glob_wildcard_matcher_tb.sv
// Self-checking testbench for glob_wildcard_matcher: a directed pass, then
// randomised patterns and texts with random idling on both stream sides.
// Depends on gwm_pkg and the glob_wildcard_matcher RTL; no files are read.

import gwm_pkg::*;

typedef logic [PATTERN_BYTES_DEF:0] posset_t;

class glob_checker;
	typedef struct {
		bit matched;
		int text_id;
	} verdict_t;

	logic [WORD_W-1:0] pat_word [PATTERN_WORDS];
	logic [LEN_W-1:0]  pat_len;
	posset_t           live_pos;
	posset_t           skip_pos;
	verdict_t          expected_match [$];
	int                texts_done;
	int                errors;

	function new();
		foreach (pat_word[w])
			pat_word[w] = '0;
		pat_len = '0;
		texts_done = 0;
		errors = 0;
		rewind();
	endfunction

	function void rewind();
		live_pos = posset_t'(1);
		skip_pos = '0;
	endfunction

	function void write_reg(reg_idx_t idx, logic [WORD_W-1:0] d);
		if (idx == REG_PATTERN_LENGTH)
			pat_len = d[LEN_W-1:0];
		else
			pat_word[int'(idx)] = d;
	endfunction

	function logic [BYTE_W-1:0] glob_byte(int k);
		if (k >= STORED_BYTES)
			return NUL_BYTE;
		return pat_word[k / 8][(k % 8) * 8 +: 8];
	endfunction

	// a live star also keeps the position after it alive
	function posset_t close_stars(posset_t s, int len);
		int p;
		for (p = 0; p < len; p++)
			if (s[p] && glob_byte(p) == STAR_BYTE)
				s[p + 1] = 1'b1;
		return s;
	endfunction

	function void push_verdict(posset_t cur, int len);
		verdict_t v;
		v.matched = cur[len];
		v.text_id = texts_done;
		expected_match.push_back(v);
		texts_done++;
		rewind();
	endfunction

	function void note_text(logic [BYTE_W-1:0] b, logic last, logic empty);
		int lim, len, k, p;
		posset_t msk, cur, nxt_live, nxt_skip;
		logic cont;
		lim = (pat_len > PATTERN_BYTES_DEF) ? PATTERN_BYTES_DEF : int'(pat_len);
		len = lim;
		for (k = lim - 1; k >= 0; k--)
			if (glob_byte(k) == NUL_BYTE)
				len = k;
		msk = '1;
		msk = msk >> (PATTERN_BYTES_DEF - len);
		if (empty) begin
			push_verdict(close_stars(posset_t'(1), len), len);
			return;
		end
		cont = (b & CONT_MASK) == CONT_VAL;
		cur = (live_pos | (cont ? posset_t'(0) : skip_pos)) & msk;
		nxt_skip = (cont ? skip_pos : posset_t'(0)) & msk;
		nxt_live = '0;
		cur = close_stars(cur, len);
		for (p = 0; p < len; p++) begin
			if (cur[p]) begin
				if (glob_byte(p) == STAR_BYTE) begin
					nxt_live[p] = 1'b1;
				end else if (glob_byte(p) == QUERY_BYTE) begin
					if (b[7])
						nxt_skip[p + 1] = 1'b1;
					else
						nxt_live[p + 1] = 1'b1;
				end else if (glob_byte(p) == b) begin
					nxt_live[p + 1] = 1'b1;
				end
			end
		end
		live_pos = nxt_live;
		skip_pos = nxt_skip;
		if (last)
			push_verdict(close_stars(nxt_live | nxt_skip, len), len);
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 50)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	task check_match(logic [7:0] d);
		verdict_t v;
		if (expected_match.size() == 0) begin
			report($sformatf("result matched=%0b with no text outstanding", d[0]));
			return;
		end
		v = expected_match.pop_front();
		if (d[0] !== v.matched)
			report($sformatf("text %0d: matched=%0b, want %0b", v.text_id, d[0], v.matched));
		if (d[7:1] !== 7'd0)
			report($sformatf("text %0d: tdata padding %h not zero", v.text_id, d[7:1]));
	endtask

	function int awaiting();
		return expected_match.size();
	endfunction
endclass

module glob_wildcard_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;   // [7:0] text_byte
	logic                 s_axis_tlast;   // last_of_text
	logic                 s_axis_tuser;   // [0] empty_text
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [7:0]           m_axis_tdata;   // [0] matched, [7:1] zero
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	glob_checker board = new();

	// stimulus state shared by the driving tasks
	logic [7:0] pat_buf [STORED_BYTES];   // pattern bytes as written to the words
	int         pat_used;                 // bytes of pat_buf the block really uses
	logic [7:0] txt [$];                  // next text to stream
	bit         idle_on = 1'b1;           // clear for a stretch with no idling
	int         rx_hold_len = 0;          // request a long receiver hold-off

	glob_wildcard_matcher uut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Sample both streams at the falling edge before the edge that takes the
	// transaction: every input changes only at the rising edge, so the values
	// seen here are the ones the block sees at the next edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_match(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				board.note_text(s_axis_tdata, s_axis_tlast, s_axis_tuser);
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	// Bytes biased towards the pattern's literals and towards UTF-8 lead and
	// continuation bytes, so that '?' swallowing is exercised often.
	function automatic logic [7:0] text_symbol();
		case ($urandom_range(0, 7))
			0: return 8'h61;          // 'a'
			1: return 8'h62;          // 'b'
			2: return 8'hC3;          // two-byte lead
			3: return 8'hA9;          // continuation
			4: return CONT_VAL;
			5: return 8'hBF;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [7:0] pattern_symbol();
		case ($urandom_range(0, 7))
			0, 1: return STAR_BYTE;
			2, 3: return QUERY_BYTE;
			default: return text_symbol();
		endcase
	endfunction

	// Offer one transaction; hold tvalid high into the next call unless a gap
	// is drawn, so back-to-back bytes never lower and raise it in one step.
	task automatic send_item(logic [7:0] b, logic last, logic empty);
		int gap;
		bit fire;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		s_axis_tuser <= empty;
		do begin
			@(negedge clk);
			fire = s_axis_tready;
			@(posedge clk);
		end while (!fire);
	endtask

	// An empty text travels as one transaction flagged in tuser; its byte
	// and tlast are don't-care, so randomise them.
	task automatic send_text();
		if (txt.size() == 0)
			send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		else
			foreach (txt[i])
				send_item(txt[i], i == txt.size() - 1, 1'b0);
	endtask

	// Write all four pattern words from pat_buf, then the length register.
	task automatic program_pattern(logic [LEN_W-1:0] lenf);
		reg_idx_t idx;
		logic [WORD_W-1:0] d;
		bit fire;
		int k;
		idx = idx.first();
		do begin
			d = '0;
			if (idx == REG_PATTERN_LENGTH) begin
				d[LEN_W-1:0] = lenf;
			end else begin
				for (k = 0; k < 8; k++)
					d[k * 8 +: 8] = pat_buf[int'(idx) * 8 + k];
			end
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= d;
			do begin
				@(negedge clk);
				fire = cfg_ready;
				@(posedge clk);
			end while (!fire);
			board.write_reg(idx, d);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_valid <= 1'b0;
	endtask

	// Drop tvalid, wait for every outstanding result, then let the pipeline
	// run empty: a trailing byte without tlast may still be in flight.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.awaiting() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Short patterns mostly, now and then a long one; bytes past the length
	// hold random junk so every bit of the pattern words toggles.
	task automatic random_pattern(output logic [LEN_W-1:0] lenf);
		int n, k, lim;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, STORED_BYTES) : $urandom_range(0, 8);
		foreach (pat_buf[i])
			pat_buf[i] = 8'($urandom_range(0, 255));
		for (k = 0; k < n; k++)
			pat_buf[k] = pattern_symbol();
		if (n > 0 && $urandom_range(0, 9) == 0)
			pat_buf[$urandom_range(0, n - 1)] = NUL_BYTE;
		lenf = LEN_W'(n);
		if (n == STORED_BYTES && $urandom_range(0, 1) == 0)
			lenf = LEN_W'($urandom_range(STORED_BYTES + 1, 63));
		lim = (n < STORED_BYTES) ? n : STORED_BYTES;
		pat_used = lim;
		for (k = lim - 1; k >= 0; k--)
			if (pat_buf[k] == NUL_BYTE)
				pat_used = k;
	endtask

	// Build a text by walking the live pattern, so that most texts get deep
	// into the position set; the rest are empty, noise or mutated walks.
	task automatic build_text();
		int r, m, k, pos;
		logic [7:0] b;
		txt.delete();
		r = $urandom_range(0, 99);
		if (r < 8)
			return;
		if (r < 25) begin
			m = $urandom_range(1, 12);
			repeat (m) txt.push_back(8'($urandom_range(1, 255)));
			return;
		end
		for (k = 0; k < pat_used; k++) begin
			if (pat_buf[k] == STAR_BYTE) begin
				repeat ($urandom_range(0, 3)) txt.push_back(text_symbol());
			end else if (pat_buf[k] == QUERY_BYTE) begin
				b = text_symbol();
				txt.push_back(b);
				if (b[7])
					repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else begin
				txt.push_back(pat_buf[k]);
			end
		end
		if (r >= 70 && txt.size() > 0) begin
			pos = $urandom_range(0, txt.size() - 1);
			case ($urandom_range(0, 2))
				0: txt[pos] = text_symbol();
				1: txt.delete(pos);
				default: txt.insert(pos, text_symbol());
			endcase
		end
		while (txt.size() > 48)
			void'(txt.pop_back());
	endtask

	// Receiver: random stalls, stretches of steady ready, and a long
	// hold-off on request, counted here so the sender carries on meanwhile.
	initial begin : receiver
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_len > 0) begin
				hold_left = rx_hold_len;
				rx_hold_len = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!idle_on) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = gap_len() - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [LEN_W-1:0] lenf;
		int phase;
		int sent;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PATTERN_WORD_0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// '?*Z': empty text, a two-byte character swallowed by '?', a miss,
		// and a NUL text byte taken by '?'
		pat_buf = '{default: NUL_BYTE};
		pat_buf[0] = QUERY_BYTE;
		pat_buf[1] = STAR_BYTE;
		pat_buf[2] = 8'h5A;                   // 'Z'
		program_pattern(3);
		send_item(8'hFF, 1'b1, 1'b1);
		txt = '{8'hC3, 8'hA9, 8'h5A};
		send_text();
		txt = '{8'h01, 8'hFF};
		send_text();
		txt = '{NUL_BYTE, 8'h5A};
		send_text();
		drain();

		// lone star, length over capacity, NUL ending the pattern early
		pat_buf = '{default: NUL_BYTE};
		pat_buf[0] = STAR_BYTE;
		program_pattern(63);
		send_item(8'h01, 1'b0, 1'b1);
		txt = '{8'hFF};
		send_text();
		drain();

		// every pattern bit set, full length
		pat_buf = '{default: 8'hFF};
		program_pattern(32);
		txt = '{8'hFF};
		send_text();
		drain();

		// same words, zero length: only the empty text matches
		program_pattern(0);
		send_item(NUL_BYTE, 1'b1, 1'b1);
		txt = '{8'h61};
		send_text();
		drain();

		// 'a?': '?' still swallowing continuation bytes when the text ends
		pat_buf = '{default: NUL_BYTE};
		pat_buf[0] = 8'h61;                   // 'a'
		pat_buf[1] = QUERY_BYTE;
		program_pattern(2);
		txt = '{8'h61, 8'hE2, 8'h82};
		send_text();
		drain();

		// Random phases: new pattern each time, block idle for every write.
		// Every fourth phase runs without idling; phase two holds the
		// receiver off long enough for the input to back up.
		for (phase = 0; phase < 20; phase++) begin
			random_pattern(lenf);
			program_pattern(lenf);
			idle_on = (phase % 4 != 1);
			if (phase == 2)
				rx_hold_len = 300;
			sent = 0;
			while (sent < 75) begin
				build_text();
				send_text();
				sent += (txt.size() == 0) ? 1 : txt.size();
			end
			drain();
		end

		if (board.errors == 0)
			$display("glob_wildcard_matcher_tb passed");
		else
			$display("glob_wildcard_matcher_tb failed");
		$finish;
	end

	// guard against a hung handshake or a result that never arrives
	initial begin : watchdog
		#5_000_000;
		$display("glob_wildcard_matcher_tb failed");
		$finish;
	end

endmodule
